/* rtl/snspd_pkg.sv */
// snspd_pkg: shared types, constants and saturating fixed-point helpers
// for the circuit step block; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package snspd_pkg;
	localparam int WordW = 32;
	localparam int FracW = 16;
	localparam int RegW = 31;
	localparam int NumRegs = 7;
	localparam int IdxW = 3;
	localparam int ProgW = 6;

	typedef logic signed [WordW-1:0] word_t;

	typedef enum logic [IdxW-1:0] {
		REG_X1 = 3'd0, REG_X2 = 3'd1, REG_Y = 3'd2, REG_RP = 3'd3,
		REG_RL = 3'd4, REG_RS = 3'd5, REG_IB = 3'd6
	} reg_idx_t;

	// datapath operations
	typedef enum logic [2:0] {
		OP_ADD, OP_SUB, OP_MUL, OP_DIV
	} op_t;

	// operand / result slots
	typedef enum logic [4:0] {
		S_X1, S_X2, S_Y, S_RP, S_RL, S_RS, S_IB, S_RW, S_I1, S_I2, S_VC, S_PR,
		S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_T7, S_T8, S_T9, S_T10, S_T11,
		S_ZERO
	} slot_t;

	typedef struct packed {
		logic  start;
		op_t   op;
		slot_t a;
		slot_t b;
		slot_t d;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic zero;
	} stat_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_ISSUE, ST_WAIT, ST_DONE, ST_OUT
	} state_t;

	localparam logic signed [WordW-1:0] WMax = {1'b0, {(WordW-1){1'b1}}};
	localparam logic signed [WordW-1:0] WMin = {1'b1, {(WordW-1){1'b0}}};

	function automatic word_t sat_add(input word_t a, input word_t b);
		logic signed [WordW:0] s;
		s = {a[WordW-1], a} + {b[WordW-1], b};
		if (s[WordW] != s[WordW-1]) sat_add = s[WordW] ? WMin : WMax;
		else sat_add = s[WordW-1:0];
	endfunction

	function automatic word_t sat_neg(input word_t a);
		sat_neg = (a == WMin) ? WMax : -a;
	endfunction

	function automatic logic [WordW-1:0] mag(input word_t a);
		mag = a[WordW-1] ? (~a + 1'b1) : a;
	endfunction

	function automatic word_t from_sign(input logic neg, input logic [WordW-1:0] m,
			input logic ovf);
		if (neg) begin
			if (ovf || m > {1'b1, {(WordW-1){1'b0}}}) from_sign = WMin;
			else from_sign = -m;
		end else begin
			if (ovf || m[WordW-1]) from_sign = WMax;
			else from_sign = m;
		end
	endfunction

	function automatic word_t sat32(input word_t a);
		sat32 = a;
	endfunction
endpackage
`default_nettype wire

/* rtl/snspd_datapath.sv */
// snspd_datapath: operand file, one shared multiplier and a bit-serial divider
// depends on snspd_pkg
`timescale 1ns / 1ps
`default_nettype none
module snspd_datapath import snspd_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [IdxW-1:0] cfg_idx,
	input  wire logic [WordW-1:0] cfg_data,
	input  wire logic          load_in,
	input  wire logic [RegW-1:0] in_rw,
	input  wire logic          commit,
	input  wire cmd_t          cmd,
	output stat_t              stat,
	output word_t              o_n1,
	output word_t              o_n2,
	output word_t              o_nv
);
	localparam int DivN = WordW + FracW;
	localparam int CntW = $clog2(DivN + 2);

	word_t slot_q [0:S_ZERO];
	word_t a_q, b_q;
	logic  busy_q;
	logic  [CntW-1:0] cnt_q;
	op_t   op_q;
	slot_t d_q;
	logic  [DivN-1:0] num_q;
	logic  [WordW:0] rem_q;
	logic  [DivN-1:0] quo_q;
	logic  [WordW-1:0] den_q;
	logic  neg_q;
	logic  [2*WordW-1:0] prod_q;
	word_t res;
	word_t rd_a, rd_b;
	logic  [WordW:0] rem_sh;

	assign rd_a = (cmd.a == S_ZERO) ? '0 : slot_q[cmd.a];
	assign rd_b = (cmd.b == S_ZERO) ? '0 : slot_q[cmd.b];
	assign rem_sh = {rem_q[WordW-1:0], num_q[DivN-1]};

	always_comb begin
		res = '0;
		case (op_q)
			OP_ADD: res = sat_add(a_q, b_q);
			OP_SUB: res = sat_add(a_q, sat_neg(b_q));
			OP_MUL: res = from_sign(neg_q, prod_q[FracW +: WordW],
				|prod_q[2*WordW-1:FracW+WordW]);
			OP_DIV: res = (den_q == '0) ? '0 : from_sign(neg_q, quo_q[WordW-1:0],
				|quo_q[DivN-1:WordW]);
			default: res = '0;
		endcase
	end

	assign stat.busy = busy_q;
	assign stat.zero = (slot_q[S_T11] == '0);
	assign o_n1 = slot_q[S_T8];
	assign o_n2 = slot_q[S_T9];
	assign o_nv = slot_q[S_T10];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			op_q <= OP_ADD;
			d_q <= S_T0;
			a_q <= '0;
			b_q <= '0;
			neg_q <= 1'b0;
			num_q <= '0;
			den_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			prod_q <= '0;
			for (int i = 0; i <= S_ZERO; i++) slot_q[i] <= '0;
		end else begin
			if (cfg_we && cfg_idx < IdxW'(NumRegs))
				slot_q[cfg_idx] <= (cfg_idx == REG_IB) ? cfg_data :
					{1'b0, cfg_data[RegW-1:0]};
			if (load_in) slot_q[S_RW] <= {1'b0, in_rw};
			if (commit) begin
				slot_q[S_I1] <= slot_q[S_T8];
				slot_q[S_I2] <= slot_q[S_T9];
				slot_q[S_VC] <= slot_q[S_T10];
				slot_q[S_PR] <= slot_q[S_RW];
			end
			if (cmd.start) begin
				busy_q <= 1'b1;
				op_q <= cmd.op;
				d_q <= cmd.d;
				a_q <= rd_a;
				b_q <= rd_b;
				neg_q <= rd_a[WordW-1] ^ rd_b[WordW-1];
				num_q <= {mag(rd_a), {FracW{1'b0}}};
				den_q <= mag(rd_b);
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= (cmd.op == OP_DIV) ? CntW'(DivN) :
					(cmd.op == OP_MUL) ? CntW'(1) : '0;
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
					if (op_q == OP_MUL) prod_q <= mag(a_q) * mag(b_q);
					else begin
						num_q <= num_q << 1;
						if (rem_sh >= {1'b0, den_q}) begin
							rem_q <= rem_sh - {1'b0, den_q};
							quo_q <= {quo_q[DivN-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							quo_q <= {quo_q[DivN-2:0], 1'b0};
						end
					end
				end else begin
					busy_q <= 1'b0;
					slot_q[d_q] <= res;
				end
			end
		end
	end
endmodule
`default_nettype wire

/* rtl/snspd_ctrl.sv */
// snspd_ctrl: sequencer stepping through the operation program for one word
// depends on snspd_pkg
`timescale 1ns / 1ps
`default_nettype none
module snspd_ctrl import snspd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_go,
	input  wire logic in_restart,
	input  wire stat_t stat,
	input  wire logic out_taken,
	output cmd_t      cmd,
	output logic      busy,
	output logic      out_valid,
	output logic      commit,
	output logic      sing
);
	state_t state_q, state_d;
	logic [ProgW-1:0] pc_q;
	logic rst_q, sing_q;
	cmd_t pcmd;
	logic last, chk;
	logic chk_q, last_q;

	function automatic cmd_t mk(input op_t o, input slot_t a, input slot_t b,
			input slot_t d);
		mk = '{start: 1'b1, op: o, a: a, b: b, d: d};
	endfunction

	// step program: T11 is checked for zero where chk is set
	always_comb begin
		pcmd = mk(OP_ADD, S_ZERO, S_ZERO, S_T0);
		last = 1'b0;
		chk = 1'b0;
		if (rst_q) begin
			unique case (pc_q)
				6'd0: begin pcmd = mk(OP_ADD, S_RS, S_RP, S_T11); chk = 1'b1; end
				6'd1: pcmd = mk(OP_MUL, S_RP, S_IB, S_T0);
				6'd2: pcmd = mk(OP_DIV, S_T0, S_T11, S_T8);
				6'd3: pcmd = mk(OP_MUL, S_RS, S_IB, S_T0);
				6'd4: pcmd = mk(OP_DIV, S_T0, S_T11, S_T9);
				6'd5: pcmd = mk(OP_MUL, S_RS, S_RP, S_T0);
				6'd6: pcmd = mk(OP_MUL, S_T0, S_IB, S_T0);
				6'd7: begin pcmd = mk(OP_DIV, S_T0, S_T11, S_T10); last = 1'b1; end
				default: last = 1'b1;
			endcase
		end else begin
			unique case (pc_q)
				6'd0:  pcmd = mk(OP_ADD, S_RL, S_RL, S_T0);
				6'd1:  pcmd = mk(OP_MUL, S_T0, S_IB, S_T0);
				6'd2:  pcmd = mk(OP_ADD, S_VC, S_T0, S_T0);
				6'd3:  pcmd = mk(OP_SUB, S_X1, S_RL, S_T1);
				6'd4:  pcmd = mk(OP_SUB, S_T1, S_PR, S_T1);
				6'd5:  pcmd = mk(OP_SUB, S_T1, S_RS, S_T1);
				6'd6:  pcmd = mk(OP_MUL, S_T1, S_I1, S_T1);
				6'd7:  pcmd = mk(OP_ADD, S_T0, S_T1, S_T1);
				6'd8:  pcmd = mk(OP_MUL, S_RL, S_I2, S_T2);
				6'd9:  pcmd = mk(OP_SUB, S_T1, S_T2, S_T1);
				6'd10: pcmd = mk(OP_SUB, S_X2, S_RL, S_T2);
				6'd11: pcmd = mk(OP_SUB, S_T2, S_RP, S_T2);
				6'd12: pcmd = mk(OP_SUB, S_T2, S_RP, S_T2);
				6'd13: pcmd = mk(OP_MUL, S_T2, S_I2, S_T2);
				6'd14: pcmd = mk(OP_ADD, S_T0, S_T2, S_T2);
				6'd15: pcmd = mk(OP_MUL, S_RL, S_I1, S_T3);
				6'd16: pcmd = mk(OP_SUB, S_T2, S_T3, S_T2);
				6'd17: pcmd = mk(OP_ADD, S_IB, S_IB, S_T3);
				6'd18: pcmd = mk(OP_SUB, S_T3, S_I1, S_T3);
				6'd19: pcmd = mk(OP_SUB, S_T3, S_I2, S_T3);
				6'd20: pcmd = mk(OP_MUL, S_Y, S_T3, S_T3);
				6'd21: pcmd = mk(OP_ADD, S_VC, S_T3, S_T3);
				6'd22: pcmd = mk(OP_ADD, S_T1, S_T3, S_T1);
				6'd23: pcmd = mk(OP_ADD, S_T2, S_T3, S_T2);
				6'd24: pcmd = mk(OP_ADD, S_X1, S_RL, S_T4);
				6'd25: pcmd = mk(OP_ADD, S_T4, S_RW, S_T4);
				6'd26: pcmd = mk(OP_ADD, S_T4, S_RS, S_T4);
				6'd27: pcmd = mk(OP_ADD, S_T4, S_Y, S_T4);
				6'd28: pcmd = mk(OP_ADD, S_RL, S_Y, S_T5);
				6'd29: pcmd = mk(OP_ADD, S_X2, S_RL, S_T6);
				6'd30: pcmd = mk(OP_ADD, S_T6, S_Y, S_T6);
				6'd31: pcmd = mk(OP_MUL, S_T4, S_T6, S_T7);
				6'd32: pcmd = mk(OP_MUL, S_T5, S_T5, S_T11);
				6'd33: begin pcmd = mk(OP_SUB, S_T7, S_T11, S_T11); chk = 1'b1; end
				6'd34: pcmd = mk(OP_MUL, S_T1, S_T6, S_T7);
				6'd35: pcmd = mk(OP_MUL, S_T5, S_T2, S_T0);
				6'd36: pcmd = mk(OP_SUB, S_T7, S_T0, S_T7);
				6'd37: pcmd = mk(OP_DIV, S_T7, S_T11, S_T8);
				6'd38: pcmd = mk(OP_MUL, S_T4, S_T2, S_T7);
				6'd39: pcmd = mk(OP_MUL, S_T5, S_T1, S_T0);
				6'd40: pcmd = mk(OP_SUB, S_T7, S_T0, S_T7);
				6'd41: pcmd = mk(OP_DIV, S_T7, S_T11, S_T9);
				6'd42: pcmd = mk(OP_ADD, S_T8, S_T9, S_T0);
				6'd43: pcmd = mk(OP_MUL, S_Y, S_T0, S_T0);
				6'd44: begin pcmd = mk(OP_SUB, S_T3, S_T0, S_T10); last = 1'b1; end
				default: last = 1'b1;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_go) state_d = ST_ISSUE;
			ST_ISSUE: state_d = ST_WAIT;
			ST_WAIT:  if (!stat.busy) state_d = ST_DONE;
			ST_DONE:  if ((chk_q && stat.zero) || last_q) state_d = ST_OUT;
				else state_d = ST_ISSUE;
			ST_OUT:   if (out_taken) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != ST_IDLE);
		out_valid = (state_q == ST_OUT);
		commit = 1'b0;
		sing = sing_q;
		unique case (state_q)
			ST_ISSUE: cmd = pcmd;
			ST_DONE:  commit = !(chk_q && stat.zero) && last_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= '0;
			rst_q <= 1'b0;
			sing_q <= 1'b0;
			chk_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && in_go) begin
				pc_q <= '0;
				rst_q <= in_restart;
				sing_q <= 1'b0;
			end
			if (state_q == ST_ISSUE) begin
				chk_q <= chk;
				last_q <= last;
			end
			if (state_q == ST_DONE) begin
				pc_q <= pc_q + 1'b1;
				if (chk_q && stat.zero) sing_q <= 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

/* rtl/snspd_parallel_circuit_step_top.sv */
// channel   dir  tdata fields (low bit first)                       tuser
// s_axis    in   wire_resistance[30:0], pad                          restart
// m_axis    out  wire_current, branch_current, cap_voltage           singular
// one word at a time: a step runs 45 shared operations, one after another
// through the single shared add/sub, multiply and divide datapath.
// reset clears state and registers; the result word holds until taken and
// the input stays blocked until then
// singular steps stop at the determinant check and leave the held state untouched
`timescale 1ns / 1ps
`default_nettype none
module snspd_parallel_circuit_step_top import snspd_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_idx,
	input  wire logic [31:0]  cfg_data,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [31:0]  s_axis_tdata,   // wire_resistance[30:0], zero
	input  wire logic         s_axis_tuser,   // restart
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [95:0]       m_axis_tdata,   // wire_current, branch_current, cap_voltage
	output logic              m_axis_tuser    // singular
);
	cmd_t  cmd;
	stat_t stat;
	logic  busy, commit, sing, go;
	word_t n1, n2, nv;

	assign s_axis_tready = !busy;
	assign go = s_axis_tvalid && s_axis_tready;

	snspd_ctrl u_ctrl (
		.clk, .arst_n, .in_go(go), .in_restart(s_axis_tuser), .stat,
		.out_taken(m_axis_tready), .cmd, .busy, .out_valid(m_axis_tvalid),
		.commit, .sing
	);

	snspd_datapath u_dp (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data, .load_in(go),
		.in_rw(s_axis_tdata[RegW-1:0]), .commit, .cmd, .stat,
		.o_n1(n1), .o_n2(n2), .o_nv(nv)
	);

	assign m_axis_tdata = sing ? '0 : {nv, n2, n1};
	assign m_axis_tuser = sing;

`ifndef SYNTHESIS
	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("ready during output");
	a_commit_not_sing: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> !m_axis_tuser) else $error("commit on singular");
	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> busy) else $error("accept without busy");
`endif
endmodule
`default_nettype wire
